// File: rtl/ftda_pkg.sv
`timescale 1ns / 1ps

package ftda_pkg;

  // Character codes
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_DOT   = 8'h2E;

  // Integer part is at most 2^31-1, which has ten decimal digits
  localparam int INT_DIGITS = 10;

  // Fixed input layout and work widths
  localparam int VALUE_W = 64;
  localparam int WORK_W  = 32;
  localparam int QUOT_W  = 29;  // 2^32 / 10 fits in 29 bits
  localparam int SCALE_W = 30;  // 10^9 fits in 30 bits

  typedef enum logic [2:0] {
    S_IDLE,
    S_INT,
    S_FRAC,
    S_SIGN,
    S_IDIG,
    S_DOT,
    S_FDIG
  } state_t;

  // Result of one divide-by-ten step
  typedef struct packed {
    logic [QUOT_W-1:0] quot;
    logic [3:0]        rem;
  } div10_t;

  // Ten to the power n, evaluated at elaboration
  function automatic logic [SCALE_W-1:0] pow10(input int n);
    logic [SCALE_W-1:0] p;
    p = SCALE_W'(1);
    for (int i = 0; i < n; i++) begin
      p = SCALE_W'(p * SCALE_W'(10));
    end
    return p;
  endfunction

endpackage

// File: rtl/fixed_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Sequencing: after a request is taken, the integer digits (n = 1..10) and then FRAC_DIGITS
// fraction digits are extracted, one digit per cycle, by the single divide-by-ten unit; then the
// c characters (2+FRAC_DIGITS..12+FRAC_DIGITS) leave one per cycle while m_tready is high.
// A new number is taken only once the last character of the previous one has left.
// Reset: synchronous, active high; returns the sequencer to idle, ready for a request.
module fixed_to_decimal_ascii #(
  parameter int FRAC_DIGITS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] text_char
  output logic        m_tlast    // last_char
);

  localparam int BufDepth = ftda_pkg::INT_DIGITS + FRAC_DIGITS;
  localparam int BufAw    = $clog2(BufDepth);
  localparam logic [BufAw-1:0] FracFirst = BufAw'(ftda_pkg::INT_DIGITS);
  localparam logic [BufAw-1:0] FracLast  = BufAw'(BufDepth - 1);
  localparam logic [ftda_pkg::SCALE_W-1:0] Scale = ftda_pkg::pow10(FRAC_DIGITS);

  ftda_pkg::state_t state, state_next;

  logic [BufAw-1:0]                 idx, idx_next;
  logic [BufAw-1:0]                 int_top;
  logic                             neg;
  logic [ftda_pkg::WORK_W-1:0]      work;
  logic [ftda_pkg::WORK_W-1:0]      fpart;
  logic [ftda_pkg::SCALE_W-1:0]     frac_scaled;
  logic [3:0]                       digit_buf [BufDepth];

  logic [ftda_pkg::VALUE_W-1:0]     mag_raw;
  logic [ftda_pkg::VALUE_W-1:0]     mag;
  logic [ftda_pkg::WORK_W+ftda_pkg::SCALE_W-1:0] frac_prod;
  ftda_pkg::div10_t                 dv;
  logic                             in_req;

  assign in_req  = s_tvalid && s_tready;

  // Magnitude with saturation of the most negative value
  assign mag_raw = s_tdata[63] ? (~s_tdata + 64'd1) : s_tdata;
  assign mag     = mag_raw[63] ? {1'b0, {63{1'b1}}} : mag_raw;

  // Fraction scaled to FRAC_DIGITS decimal digits, truncated
  assign frac_prod   = fpart * Scale;
  assign frac_scaled = frac_prod[ftda_pkg::WORK_W+ftda_pkg::SCALE_W-1:ftda_pkg::WORK_W];

  // Shared divide-by-ten unit
  ftda_div10 u_div10 (
    .dividend (work),
    .res      (dv)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftda_pkg::S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // Next state, index and handshake outputs
  always_comb begin
    state_next = state;
    idx_next   = idx;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    m_tdata    = ftda_pkg::ASCII_ZERO;
    m_tlast    = 1'b0;
    case (state)
      ftda_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ftda_pkg::S_INT;
          idx_next   = '0;
        end
      end
      ftda_pkg::S_INT: begin
        if (dv.quot == '0) begin
          state_next = ftda_pkg::S_FRAC;
          idx_next   = FracLast;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ftda_pkg::S_FRAC: begin
        if (idx == FracFirst) begin
          state_next = neg ? ftda_pkg::S_SIGN : ftda_pkg::S_IDIG;
          idx_next   = int_top;
        end else begin
          idx_next = idx - 1'b1;
        end
      end
      ftda_pkg::S_SIGN: begin
        m_tvalid = 1'b1;
        m_tdata  = ftda_pkg::ASCII_MINUS;
        if (m_tready) state_next = ftda_pkg::S_IDIG;
      end
      ftda_pkg::S_IDIG: begin
        m_tvalid = 1'b1;
        m_tdata  = ftda_pkg::ASCII_ZERO + {4'b0000, digit_buf[idx]};
        if (m_tready) begin
          if (idx == '0) state_next = ftda_pkg::S_DOT;
          else idx_next = idx - 1'b1;
        end
      end
      ftda_pkg::S_DOT: begin
        m_tvalid = 1'b1;
        m_tdata  = ftda_pkg::ASCII_DOT;
        if (m_tready) begin
          state_next = ftda_pkg::S_FDIG;
          idx_next   = FracFirst;
        end
      end
      ftda_pkg::S_FDIG: begin
        m_tvalid = 1'b1;
        m_tdata  = ftda_pkg::ASCII_ZERO + {4'b0000, digit_buf[idx]};
        m_tlast  = (idx == FracLast);
        if (m_tready) begin
          if (idx == FracLast) state_next = ftda_pkg::S_IDLE;
          else idx_next = idx + 1'b1;
        end
      end
      default: begin
        state_next = ftda_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath: load request, step the divider, hold digits
  always_ff @(posedge clk) begin
    if (in_req) begin
      neg   <= s_tdata[63];
      work  <= mag[63:32];
      fpart <= mag[31:0];
    end
    if (state == ftda_pkg::S_INT) begin
      digit_buf[idx] <= dv.rem;
      if (dv.quot == '0) begin
        int_top <= idx;
        work    <= {{(ftda_pkg::WORK_W - ftda_pkg::SCALE_W){1'b0}}, frac_scaled};
      end else begin
        work <= {{(ftda_pkg::WORK_W - ftda_pkg::QUOT_W){1'b0}}, dv.quot};
      end
    end
    if (state == ftda_pkg::S_FRAC) begin
      digit_buf[idx] <= dv.rem;
      work           <= {{(ftda_pkg::WORK_W - ftda_pkg::QUOT_W){1'b0}}, dv.quot};
    end
  end

endmodule

// File: rtl/ftda_div10.sv
`timescale 1ns / 1ps

module ftda_div10 (
  input  logic [ftda_pkg::WORK_W-1:0] dividend,
  output ftda_pkg::div10_t            res
);

  localparam logic [31:0] RECIP = 32'hCCCC_CCCD;  // ceil(2^35 / 10)

  logic [63:0]                        prod;
  logic [ftda_pkg::QUOT_W-1:0]        quot;
  logic [ftda_pkg::WORK_W-1:0]        quot_x10;
  logic [ftda_pkg::WORK_W-1:0]        diff;

  // Quotient by reciprocal multiply, exact for every 32-bit dividend
  assign prod = 64'(dividend) * 64'(RECIP);
  assign quot = prod[63:35];

  // Remainder: dividend minus quotient times ten
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign diff     = dividend - quot_x10;

  assign res.quot = quot;
  assign res.rem  = diff[3:0];

endmodule
